### hdl/msp_pkg.sv
package msp_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int UNITS = 3;

    typedef logic signed [33:0] cw_t;
    typedef logic signed [31:0] q30_t;
    typedef logic [1:0] quad_t;

    localparam cw_t CORDIC_GAIN = 34'sd652032874;
    localparam q30_t RADIUS = 32'sd1342177280;
    localparam q30_t OCTANT = 32'sh2000_0000;

    function automatic q30_t atan_turn(input int idx);
        q30_t a;
        case (idx)
            0: a = 32'sd536870912;
            1: a = 32'sd316933406;
            2: a = 32'sd167458907;
            3: a = 32'sd85004756;
            4: a = 32'sd42667331;
            5: a = 32'sd21354465;
            6: a = 32'sd10679838;
            7: a = 32'sd5340245;
            8: a = 32'sd2670163;
            9: a = 32'sd1335087;
            10: a = 32'sd667544;
            11: a = 32'sd333772;
            12: a = 32'sd166886;
            13: a = 32'sd83443;
            14: a = 32'sd41722;
            15: a = 32'sd20861;
            16: a = 32'sd10430;
            17: a = 32'sd5215;
            18: a = 32'sd2608;
            19: a = 32'sd1304;
            20: a = 32'sd652;
            21: a = 32'sd326;
            22: a = 32'sd163;
            23: a = 32'sd81;
            24: a = 32'sd41;
            25: a = 32'sd20;
            26: a = 32'sd10;
            27: a = 32'sd5;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

endpackage

### hdl/mobius_strip_surface_point_core.sv
// channel   signals                                   direction
// request   in_valid in_ready sweep_phase ellipse_phase  in
// result    out_valid out_ready pos_x pos_y pos_z     out
// config    cfg_valid cfg_ready scale                 in
//
// one request per cycle unless a stalled output has backed up every stage,
// 28 cordic stages plus six: angle setup, quadrant fold, products and scaling
// three cordic units run side by side, one iteration each per stage
// reset clears the stage valid bits and sets scale to 1.0
// each stage holds on its own, a bubble is filled even while the output stalls
module mobius_strip_surface_point_core
    import msp_pkg::*;
#(
    parameter int PHASE_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [16:0]        sweep_phase,
    input  logic [16:0]        ellipse_phase,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        scale
);

    localparam int SH = 31 - PHASE_BITS;
    localparam int N = CORDIC_STEPS + 6;
    localparam int SA = CORDIC_STEPS + 1;
    localparam int SB = CORDIC_STEPS + 2;
    localparam int SC = CORDIC_STEPS + 3;
    localparam int SD = CORDIC_STEPS + 4;
    localparam int SE = CORDIC_STEPS + 5;

    logic [N-1:0] v_reg;
    logic [N-1:0] en;
    logic [15:0]  scale_reg;

    cw_t   x_reg [CORDIC_STEPS+1][UNITS];
    cw_t   y_reg [CORDIC_STEPS+1][UNITS];
    q30_t  z_reg [CORDIC_STEPS+1][UNITS];
    quad_t q_reg [CORDIC_STEPS+1][UNITS];

    // ready chain from the output back
    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            scale_reg <= 16'd256;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (cfg_valid)
            begin
                scale_reg <= scale;
            end
        end
    end

    // angle setup: sweep u, twist u/2, ellipse t in half-phase units
    logic [31:0] half_w [UNITS];
    logic [31:0] p_w    [UNITS];

    always_comb
    begin
        half_w[0] = {14'd0, sweep_phase, 1'b0};
        half_w[1] = {15'd0, sweep_phase};
        half_w[2] = {14'd0, ellipse_phase, 1'b0};
        for (int j = 0; j < UNITS; j++)
        begin
            p_w[j] = (half_w[j] << SH) + 32'h2000_0000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < UNITS; j++)
            begin
                x_reg[0][j] <= CORDIC_GAIN;
                y_reg[0][j] <= '0;
                z_reg[0][j] <= $signed({2'b00, p_w[j][29:0]}) - OCTANT;
                q_reg[0][j] <= p_w[j][31:30];
            end
        end
    end

    // cordic iterations
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        cw_t  x_next [UNITS];
        cw_t  y_next [UNITS];
        q30_t z_next [UNITS];

        always_comb
        begin
            for (int j = 0; j < UNITS; j++)
            begin
                if (z_reg[i][j] >= 0)
                begin
                    x_next[j] = x_reg[i][j] - (y_reg[i][j] >>> i);
                    y_next[j] = y_reg[i][j] + (x_reg[i][j] >>> i);
                    z_next[j] = z_reg[i][j] - atan_turn(i);
                end
                else
                begin
                    x_next[j] = x_reg[i][j] + (y_reg[i][j] >>> i);
                    y_next[j] = y_reg[i][j] - (x_reg[i][j] >>> i);
                    z_next[j] = z_reg[i][j] + atan_turn(i);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[i+1])
            begin
                for (int j = 0; j < UNITS; j++)
                begin
                    x_reg[i+1][j] <= x_next[j];
                    y_reg[i+1][j] <= y_next[j];
                    z_reg[i+1][j] <= z_next[j];
                    q_reg[i+1][j] <= q_reg[i][j];
                end
            end
        end
    end

    // quadrant fold
    q30_t c_next [UNITS];
    q30_t s_next [UNITS];
    q30_t c_reg  [UNITS];
    q30_t s_reg  [UNITS];

    always_comb
    begin
        for (int j = 0; j < UNITS; j++)
        begin
            case (q_reg[CORDIC_STEPS][j])
                2'd0:
                begin
                    c_next[j] = x_reg[CORDIC_STEPS][j][31:0];
                    s_next[j] = y_reg[CORDIC_STEPS][j][31:0];
                end
                2'd1:
                begin
                    c_next[j] = -y_reg[CORDIC_STEPS][j][31:0];
                    s_next[j] = x_reg[CORDIC_STEPS][j][31:0];
                end
                2'd2:
                begin
                    c_next[j] = -x_reg[CORDIC_STEPS][j][31:0];
                    s_next[j] = -y_reg[CORDIC_STEPS][j][31:0];
                end
                default:
                begin
                    c_next[j] = y_reg[CORDIC_STEPS][j][31:0];
                    s_next[j] = -x_reg[CORDIC_STEPS][j][31:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[SA])
        begin
            for (int j = 0; j < UNITS; j++)
            begin
                c_reg[j] <= c_next[j];
                s_reg[j] <= s_next[j];
            end
        end
    end

    // ellipse rotation products, unit 0 sweep, 1 twist, 2 ellipse
    logic signed [63:0] p_cc, p_ss, p_cs, p_sc;
    cw_t  m_cc_reg, m_ss_reg, m_cs_reg, m_sc_reg;
    q30_t cu_b_reg, su_b_reg;

    assign p_cc = c_reg[2] * c_reg[1];
    assign p_ss = s_reg[2] * s_reg[1];
    assign p_cs = c_reg[2] * s_reg[1];
    assign p_sc = s_reg[2] * c_reg[1];

    always_ff @(posedge clk)
    begin
        if (en[SB])
        begin
            m_cc_reg <= 34'(p_cc >>> 30);
            m_ss_reg <= 34'(p_ss >>> 30);
            m_cs_reg <= 34'(p_cs >>> 30);
            m_sc_reg <= 34'(p_sc >>> 30);
            cu_b_reg <= c_reg[0];
            su_b_reg <= s_reg[0];
        end
    end

    // radius and height
    cw_t  ex_w, ey_w;
    q30_t r_reg, ey_c_reg, cu_c_reg, su_c_reg;

    assign ex_w = (m_cc_reg >>> 3) - (m_ss_reg >>> 1);
    assign ey_w = (m_cs_reg >>> 3) + (m_sc_reg >>> 1);

    always_ff @(posedge clk)
    begin
        if (en[SC])
        begin
            r_reg    <= RADIUS + ex_w[31:0];
            ey_c_reg <= ey_w[31:0];
            cu_c_reg <= cu_b_reg;
            su_c_reg <= su_b_reg;
        end
    end

    // sweep around the circle
    logic signed [63:0] p_x, p_y;
    cw_t xd_reg, yd_reg, zd_reg;

    assign p_x = r_reg * cu_c_reg;
    assign p_y = r_reg * su_c_reg;

    always_ff @(posedge clk)
    begin
        if (en[SD])
        begin
            xd_reg <= 34'(p_x >>> 30);
            yd_reg <= 34'(p_y >>> 30);
            zd_reg <= 34'(ey_c_reg);
        end
    end

    // scale, round and saturate
    function automatic logic signed [31:0] to_out(input cw_t c, input logic [15:0] sc);
        logic signed [50:0] prod;
        logic signed [50:0] v;
        logic signed [31:0] res;
        prod = c * $signed({1'b0, sc});
        v = (prod + 51'sd2097152) >>> 22;
        if (v > 51'sd2147483647)
        begin
            res = 32'sh7fff_ffff;
        end
        else if (v < -51'sd2147483648)
        begin
            res = 32'sh8000_0000;
        end
        else
        begin
            res = v[31:0];
        end
        return res;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[SE])
        begin
            pos_x <= to_out(xd_reg, scale_reg);
            pos_y <= to_out(yd_reg, scale_reg);
            pos_z <= to_out(zd_reg, scale_reg);
        end
    end

`ifndef ASSERT_OFF
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("ready chain broken");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg) && !out_ready |-> !in_ready)
        else $error("request taken into a full pipeline");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> $countones(v_reg) == $past($countones(v_reg))
            + ($past(in_valid && in_ready) ? 1 : 0)
            - ($past(out_valid && out_ready) ? 1 : 0))
        else $error("request lost or duplicated in pipeline");
`endif

endmodule

### tb/mobius_strip_surface_point_core_tb.sv
`timescale 1ns / 1ps

module mobius_strip_surface_point_core_tb;
    import msp_pkg::*;

    localparam int PHASE_BITS = 16;
    localparam int LATENCY = 34;
    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam longint GAIN = 652032874;
    localparam int N_RANDOM = 1250;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    typedef struct {
        logic [16:0] u;
        logic [16:0] t;
        bit          known;
        point_t      pt;
    } vec_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [16:0] sweep_phase;
    logic [16:0] ellipse_phase;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic cfg_valid;
    logic cfg_ready;
    logic [15:0] scale;

    point_t expected_points[$];
    logic [15:0] scale_model;
    int send_idle_pct;
    int recv_stall_pct;
    bit recv_hold;
    int mismatches = 0;
    longint cycles = 0;
    bit stim_done;

    mobius_strip_surface_point_core #(.PHASE_BITS(PHASE_BITS)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sweep_phase(sweep_phase),
        .ellipse_phase(ellipse_phase),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .scale(scale)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic void rotate_sincos(logic [31:0] half_units, output longint c,
                                          output longint s);
        logic [31:0] turn;
        logic [31:0] p;
        logic [1:0] quad;
        longint z;
        longint x;
        longint y;
        longint nx;
        turn = half_units << (31 - PHASE_BITS);
        p = turn + 32'h2000_0000;
        quad = p[31:30];
        z = longint'({2'b0, p[29:0]}) - 64'sh2000_0000;
        x = GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= longint'(atan_turn(i));
            end
            else
            begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += longint'(atan_turn(i));
            end
            x = nx;
        end
        case (quad)
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return floor_shift(a * b, 30);
    endfunction

    function automatic logic signed [31:0] scale_to_q16(longint coord, logic [15:0] sc);
        longint v;
        v = floor_shift(coord * longint'({48'b0, sc}) + (64'sd1 <<< 21), 22);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic point_t surface_point(logic [16:0] u, logic [16:0] t,
                                             logic [15:0] sc);
        longint cu, su, cp, sp, ct, st, ex, ey, r;
        point_t pt;
        rotate_sincos({14'b0, u, 1'b0}, cu, su);
        rotate_sincos({15'b0, u}, cp, sp);
        rotate_sincos({14'b0, t, 1'b0}, ct, st);
        ex = floor_shift(mul_q30(ct, cp), 3) - floor_shift(mul_q30(st, sp), 1);
        ey = floor_shift(mul_q30(ct, sp), 3) + floor_shift(mul_q30(st, cp), 1);
        r = longint'(RADIUS) + ex;
        pt.x = scale_to_q16(mul_q30(r, cu), sc);
        pt.y = scale_to_q16(mul_q30(r, su), sc);
        pt.z = scale_to_q16(ey, sc);
        return pt;
    endfunction

    task automatic send_request(logic [16:0] u, logic [16:0] t, bit known, point_t pt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sweep_phase <= u;
        ellipse_phase <= t;
        if (known)
            expected_points.push_back(pt);
        else
            expected_points.push_back(surface_point(u, t, scale_model));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_scale(logic [15:0] value);
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_valid <= 1'b1;
        scale <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        scale_model = value;
    endtask

    task automatic random_requests(int n);
        logic [16:0] u, t;
        for (int i = 0; i < n; i++)
        begin
            u = 17'(($urandom_range(15) == 0) ? 17'h10000 + $urandom_range(65535)
                                               : $urandom);
            t = 17'(($urandom_range(15) == 0) ? 17'h10000 + $urandom_range(65535)
                                               : $urandom);
            if ($urandom_range(19) == 0)
                u = 17'h1FFFF;
            send_request(u, t, 1'b0, '0);
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point x=%0d y=%0d z=%0d", pos_x, pos_y, pos_z);
            end
            else
            begin
                point_t e;
                e = expected_points.pop_front();
                if (pos_x !== e.x || pos_y !== e.y || pos_z !== e.z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d got %0d %0d %0d",
                                 e.x, e.y, e.z, pos_x, pos_y, pos_z);
                end
            end
        end
    end

    initial
    begin
        vec_row_t vectors[$];
        point_t p0;
        longint wait_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sweep_phase = '0;
        ellipse_phase = '0;
        cfg_valid = 1'b0;
        scale = '0;
        recv_hold = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stim_done = 1'b0;
        scale_model = 16'd256;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // u = t = 0: x = 1.375, y = 0, z = 0 at unit scale, within cordic error
        vectors.push_back('{17'd0, 17'd0, 1'b0, '0});
        vectors.push_back('{17'h10000, 17'd0, 1'b0, '0});
        vectors.push_back('{17'h10000, 17'h10000, 1'b0, '0});
        vectors.push_back('{17'h1FFFF, 17'h1FFFF, 1'b0, '0});
        vectors.push_back('{17'h08000, 17'h04000, 1'b0, '0});
        vectors.push_back('{17'h04000, 17'h0C000, 1'b0, '0});
        vectors.push_back('{17'h0C000, 17'h08000, 1'b0, '0});
        vectors.push_back('{17'h18000, 17'h14000, 1'b0, '0});
        vectors.push_back('{17'h00001, 17'h0FFFF, 1'b0, '0});
        vectors.push_back('{17'h15555, 17'h0AAAA, 1'b0, '0});
        foreach (vectors[i])
            send_request(vectors[i].u, vectors[i].t, vectors[i].known, vectors[i].pt);

        // zero scale gives the origin
        write_scale(16'd0);
        p0 = '0;
        send_request(17'h1FFFF, 17'h1FFFF, 1'b1, p0);
        send_request(17'h0, 17'h0, 1'b1, p0);
        send_request(17'h0AAAA, 17'h15555, 1'b1, p0);
        write_scale(16'hFFFF);
        foreach (vectors[i])
            send_request(vectors[i].u, vectors[i].t, 1'b0, '0);

        write_scale(16'd256);
        random_requests(300);

        send_idle_pct = 65;
        write_scale(16'($urandom));
        random_requests(250);

        send_idle_pct = 0;
        recv_stall_pct = 65;
        write_scale(16'd1);
        random_requests(250);

        send_idle_pct = 15;
        recv_stall_pct = 15;
        write_scale(16'($urandom_range(512)));
        random_requests(250);

        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_scale(16'hFFFF);
        fork
            begin
                recv_hold = 1'b1;
                repeat (200) @(negedge clk);
                recv_hold = 1'b0;
            end
            random_requests(200);
        join
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (expected_points.size() != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(negedge clk);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
hdl/msp_pkg.sv
hdl/mobius_strip_surface_point_core.sv
tb/mobius_strip_surface_point_core_tb.sv
